// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL files of the top-k tracker.
// Needs a clk and an active-low arst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must hold at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// when ante holds, cons must hold at the same edge
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// when ante holds, cons must hold at the next edge
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/tkst_pkg.sv
// Shared types and constants of the top-k smallest tracker.
// No dependencies; used by tkst_cell and top_k_smallest_tracker_unit.
package tkst_pkg;

	localparam int MAX_KEEP = 64;
	localparam int CNT_W = $clog2(MAX_KEEP + 1);
	localparam int DIST_W = 32;
	localparam int ID_W = 32;
	localparam int KEEP_W = 7;
	localparam int HELD_W = 7;
	localparam logic [KEEP_W-1:0] KEEP_RESET = 7'd10;

	// bit positions in the result tuser
	localparam int TU_ACC = 0;
	localparam int TU_EVI = 1;
	localparam int TU_VAL = 2;

	// distance sits above id, so a plain compare of two entries orders them
	// by distance first and id second
	typedef struct packed {
		logic [DIST_W-1:0] distance;
		logic [ID_W-1:0]   id;
	} entry_t;

	typedef enum logic [1:0] {
		OP_HOLD  = 2'd0,
		OP_INS   = 2'd1,
		OP_EVICT = 2'd2,
		OP_POP   = 2'd3
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		entry_t   cand;
	} cell_ctl_t;

endpackage

// File: rtl/tkst_cell.sv
// One cell of the sorted chain: holds one entry, compares it to the candidate.
// Depends on tkst_pkg.
module tkst_cell (
	input  logic              clk,
	input  tkst_pkg::cell_ctl_t ctl,
	input  logic              held,      // this cell holds a live entry
	input  tkst_pkg::entry_t  left_ent,  // worse-side neighbor
	input  tkst_pkg::entry_t  right_ent, // better-side neighbor
	input  logic              gt_left,
	input  logic              gt_right,
	output logic              gt,        // own entry is worse than candidate
	output tkst_pkg::entry_t  ent
);
	import tkst_pkg::*;

	entry_t ent_q;
	entry_t ent_nxt;

	assign ent = ent_q;
	assign gt = held && (ent_q > ctl.cand);

	always_comb begin
		unique case (ctl.op)
			OP_INS: begin
				// worse entries stay, candidate lands at the boundary, rest shift
				if (gt)
					ent_nxt = ent_q;
				else if (gt_left)
					ent_nxt = ctl.cand;
				else
					ent_nxt = left_ent;
			end
			OP_EVICT: begin
				// head leaves: worse entries move up, candidate fills the gap
				if (gt_right)
					ent_nxt = right_ent;
				else if (gt)
					ent_nxt = ctl.cand;
				else
					ent_nxt = ent_q;
			end
			OP_POP:  ent_nxt = right_ent;
			default: ent_nxt = ent_q;
		endcase
	end

	always_ff @(posedge clk) begin
		ent_q <= ent_nxt;
	end

endmodule

// File: rtl/top_k_smallest_tracker_unit.sv
// Top level of the top-k smallest tracker: control, output register, cell chain.
// Depends on tkst_pkg, tkst_cell and assert_macros.svh.
`include "assert_macros.svh"

// Keeps the k smallest (distance, id) candidates in a chain of MAX_KEEP cells
// sorted worst first, so the worst entry always sits in cell 0. An insert beat
// (tuser 0) works as follows: every cell compares its entry with the candidate
// in parallel and either holds, takes the candidate, or takes a neighbor's
// entry. While fewer than k entries are held the candidate is added; once k
// are held it replaces the head only when its distance is strictly smaller,
// and the old head comes back on the result beat with evicted set. A drain
// beat (tuser 1) returns the held entries worst to best, one result beat per
// cycle unless the output stalls, as the chain shifts toward the head, with
// tlast on the final one; the slave side stays held until the final entry is
// loaded; an empty drain gives a single beat with entry_valid low. keep_count
// above MAX_KEEP saturates; lowering it below the held count keeps the
// entries. No clearing pass follows reset. Results sit in one output register,
// so the next insert is taken in the same cycle the previous result is taken.
module top_k_smallest_tracker_unit (
	input  logic        clk,
	input  logic        arst_n,
	// configuration: keep_count
	input  logic        cfg_wr_en,
	input  logic [6:0]  cfg_wr_data,
	// input beats
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // [31:0] distance, [63:32] item_id
	input  logic [0:0]  s_tuser,   // [0] mode
	// result beats
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,   // [31:0] out_distance, [63:32] out_id,
	                               // [70:64] held_count, [71] zero
	output logic [2:0]  m_tuser,   // [0] accepted, [1] evicted, [2] entry_valid
	output logic        m_tlast
);
	import tkst_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE  = 2'b01,
		ST_DRAIN = 2'b10
	} state_t;

	state_t state_q;
	state_t state_nxt;

	logic [KEEP_W-1:0] keep_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  count_nxt;
	logic [CNT_W-1:0]  k_eff;

	logic        m_tvalid_q;
	logic [71:0] m_tdata_q;
	logic [2:0]  m_tuser_q;
	logic        m_tlast_q;

	logic   can_load;
	logic   acc;
	logic   in_mode;
	logic   room;
	logic   do_ins;
	logic   do_evict;
	logic   do_pop;
	logic   load;
	entry_t cand;
	entry_t head;

	cell_ctl_t ctl;
	entry_t    ent [MAX_KEEP];
	logic      gt  [MAX_KEEP];

	// ---------------------------------------------------------------- handshake
	assign can_load = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE) && can_load;
	assign acc      = s_tvalid && s_tready;
	assign in_mode  = s_tuser[0];
	assign cand     = '{distance: s_tdata[31:0], id: s_tdata[63:32]};
	assign head     = ent[0];

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

	// ---------------------------------------------------------------- decisions
	always_comb begin
		if (int'(keep_q) > MAX_KEEP)
			k_eff = CNT_W'(MAX_KEEP);
		else
			k_eff = CNT_W'(keep_q);
	end

	assign room     = count_q < k_eff;
	assign do_ins   = acc && !in_mode && room;
	// replacement looks at distance only; ties on distance never replace
	assign do_evict = acc && !in_mode && !room && (count_q != '0)
		&& (cand.distance < head.distance);
	assign do_pop   = (acc && in_mode && (count_q != '0))
		|| ((state_q == ST_DRAIN) && can_load);
	assign load     = acc || do_pop;

	always_comb begin
		ctl.cand = cand;
		if (do_ins)
			ctl.op = OP_INS;
		else if (do_evict)
			ctl.op = OP_EVICT;
		else if (do_pop)
			ctl.op = OP_POP;
		else
			ctl.op = OP_HOLD;
	end

	always_comb begin
		count_nxt = count_q;
		state_nxt = state_q;
		if (do_ins)
			count_nxt = count_q + CNT_W'(1);
		if (do_pop) begin
			count_nxt = count_q - CNT_W'(1);
			state_nxt = (count_q == CNT_W'(1)) ? ST_IDLE : ST_DRAIN;
		end
	end

	// ---------------------------------------------------------------- registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			keep_q     <= KEEP_RESET;
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			count_q <= count_nxt;
			if (cfg_wr_en)
				keep_q <= cfg_wr_data;
			if (load)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	// result payload: insert, drain of an entry, or empty drain
	always_ff @(posedge clk) begin
		if (load) begin
			m_tdata_q[71]    <= 1'b0;
			m_tdata_q[70:64] <= HELD_W'(count_nxt);
			m_tuser_q[TU_ACC] <= do_ins || do_evict;
			m_tuser_q[TU_EVI] <= do_evict;
			m_tuser_q[TU_VAL] <= do_pop;
			if (do_evict || do_pop) begin
				m_tdata_q[31:0]  <= head.distance;
				m_tdata_q[63:32] <= head.id;
			end else begin
				m_tdata_q[31:0]  <= '0;
				m_tdata_q[63:32] <= '0;
			end
			m_tlast_q <= do_pop ? (count_q == CNT_W'(1)) : 1'b1;
		end
	end

	// ---------------------------------------------------------------- cell chain
	for (genvar i = 0; i < MAX_KEEP; i++) begin : g_cell
		entry_t left_ent;
		entry_t right_ent;
		logic   gt_left;
		logic   gt_right;
		logic   held;

		assign held = CNT_W'(i) < count_q;

		if (i == 0) begin : g_head
			assign left_ent = ent[i];
			assign gt_left  = 1'b1;
		end else begin : g_mid_l
			assign left_ent = ent[i-1];
			assign gt_left  = gt[i-1];
		end

		if (i == MAX_KEEP - 1) begin : g_tail
			assign right_ent = ent[i];
			assign gt_right  = 1'b0;
		end else begin : g_mid_r
			assign right_ent = ent[i+1];
			assign gt_right  = gt[i+1];
		end

		tkst_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.held      (held),
			.left_ent  (left_ent),
			.right_ent (right_ent),
			.gt_left   (gt_left),
			.gt_right  (gt_right),
			.gt        (gt[i]),
			.ent       (ent[i])
		);
	end

	// ---------------------------------------------------------------- checks
	`ASSERT_ALWAYS(a_count_max, int'(count_q) <= MAX_KEEP, "held count above capacity")
	`ASSERT_IMPLY(a_drain_nonempty, state_q == ST_DRAIN, count_q != '0, "drain with empty chain")
	`ASSERT_IMPLY(a_ready_idle, s_tready, state_q == ST_IDLE, "input taken during drain")
	`ASSERT_IMPLY(a_last_drain_empty, m_tvalid_q && m_tlast_q && m_tuser_q[TU_VAL],
		count_q == '0, "final drain beat with entries left")
	`ASSERT_NEXT(a_evict_keeps_count, do_evict, $stable(count_q), "eviction changed count")

endmodule
